// File: hw/rtl/lmdd_pkg.sv
`default_nettype none

package lmdd_pkg;

    // Field widths of the request and result channels.
    localparam int OP_W     = 2;
    localparam int TID_W    = 4;
    localparam int MID_W    = 6;
    localparam int STATUS_W = 3;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [TID_W-1:0]    tid_t;
    typedef logic [MID_W-1:0]    mid_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request commands.
    localparam op_t OP_LOCK     = 2'd0;
    localparam op_t OP_TRY_LOCK = 2'd1;
    localparam op_t OP_UNLOCK   = 2'd2;

    // Result status codes.
    localparam status_t STATUS_GRANTED  = 3'd0;
    localparam status_t STATUS_WAIT     = 3'd1;
    localparam status_t STATUS_BUSY     = 3'd2;
    localparam status_t STATUS_DEADLOCK = 3'd3;
    localparam status_t STATUS_RELEASED = 3'd4;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_OWNER,
        S_CHAIN,
        S_CHAIN_WAIT,
        S_CHAIN_OWNER,
        S_SCAN_READ,
        S_SCAN_CHECK,
        S_DONE
    } state_t;

    // Write operations on the owner table.
    typedef enum logic [2:0] {
        OWN_WR_NONE,
        OWN_WR_CLEAR,
        OWN_WR_GRANT,
        OWN_WR_HAND,
        OWN_WR_FREE
    } own_wr_t;

    // Write operations on the wait table.
    typedef enum logic [2:0] {
        WAIT_WR_NONE,
        WAIT_WR_CLEAR,
        WAIT_WR_SET,
        WAIT_WR_DROP,
        WAIT_WR_WAKE
    } wait_wr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_req;
        logic     clear_step;
        logic     own_rd_chain;
        logic     wait_rd_scan;
        own_wr_t  own_wr;
        wait_wr_t wait_wr;
        logic     chain_start;
        logic     chain_step;
        logic     scan_start;
        logic     scan_step;
        logic     res_set;
        status_t  res_status;
        logic     res_woken;
        logic     out_load;
    } dp_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_ok;
        op_t  op;
        logic own_valid;
        logic own_is_req;
        logic cur_is_req;
        logic step_done;
        logic wait_valid;
        logic wait_match;
        logic scan_last;
        logic clear_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lmdd_if.sv
`default_nettype none

// Request channel: one lock, try-lock or unlock request per transfer.
interface lmdd_req_if;
    import lmdd_pkg::*;

    logic valid;
    logic ready;
    op_t  command;
    tid_t thread_id;
    mid_t mutex_id;

    modport source (output valid, output command, output thread_id, output mutex_id,
                    input ready);
    modport sink (input valid, input command, input thread_id, input mutex_id,
                  output ready);
endinterface

// Result channel: one result per request transfer.
interface lmdd_rsp_if;
    import lmdd_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    logic    woken_valid;
    tid_t    woken_thread;

    modport source (output valid, output status, output woken_valid, output woken_thread,
                    input ready);
    modport sink (input valid, input status, input woken_valid, input woken_thread,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lmdd_ram.sv
`default_nettype none

module lmdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/lmdd_ctrl.sv
`default_nettype none

module lmdd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output lmdd_pkg::dp_ctl_t       ctl,
    input  wire lmdd_pkg::dp_stat_t stat
);
    import lmdd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctl         = '0;
        ctl.own_wr  = OWN_WR_NONE;
        ctl.wait_wr = WAIT_WR_NONE;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep both tables back to their empty state after reset.
                ctl.clear_step = 1'b1;
                ctl.own_wr     = OWN_WR_CLEAR;
                ctl.wait_wr    = WAIT_WR_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // The owner table read of the requested mutex starts here.
                if (!stat.req_ok)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_BUSY;
                    state_next     = S_DONE;
                end
                else if (stat.op == OP_UNLOCK)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN_READ;
                end
                else
                begin
                    state_next = S_OWNER;
                end
            end

            S_OWNER:
            begin
                if (stat.op == OP_LOCK && stat.own_valid && !stat.own_is_req)
                begin
                    // Owned by another thread: walk the owner chain.
                    ctl.chain_start = 1'b1;
                    state_next      = S_CHAIN;
                end
                else if (stat.op == OP_TRY_LOCK && stat.own_valid)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_BUSY;
                    state_next     = S_DONE;
                end
                else
                begin
                    ctl.own_wr     = OWN_WR_GRANT;
                    ctl.wait_wr    = WAIT_WR_DROP;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_GRANTED;
                    state_next     = S_DONE;
                end
            end

            S_CHAIN:
            begin
                if (stat.step_done)
                begin
                    ctl.wait_wr    = WAIT_WR_SET;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_WAIT;
                    state_next     = S_DONE;
                end
                else if (stat.cur_is_req)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_DEADLOCK;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_CHAIN_WAIT;
                end
            end

            S_CHAIN_WAIT:
            begin
                // The current thread's wait entry is on the read port now.
                if (!stat.wait_valid)
                begin
                    ctl.wait_wr    = WAIT_WR_SET;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_WAIT;
                    state_next     = S_DONE;
                end
                else
                begin
                    ctl.own_rd_chain = 1'b1;
                    state_next       = S_CHAIN_OWNER;
                end
            end

            S_CHAIN_OWNER:
            begin
                if (!stat.own_valid)
                begin
                    ctl.wait_wr    = WAIT_WR_SET;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_WAIT;
                    state_next     = S_DONE;
                end
                else
                begin
                    ctl.chain_step = 1'b1;
                    state_next     = S_CHAIN;
                end
            end

            S_SCAN_READ:
            begin
                ctl.wait_rd_scan = 1'b1;
                state_next       = S_SCAN_CHECK;
            end

            S_SCAN_CHECK:
            begin
                // Lowest-numbered waiter on this mutex becomes the owner.
                if (stat.wait_valid && stat.wait_match)
                begin
                    ctl.own_wr     = OWN_WR_HAND;
                    ctl.wait_wr    = WAIT_WR_WAKE;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_RELEASED;
                    ctl.res_woken  = 1'b1;
                    state_next     = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    ctl.own_wr     = OWN_WR_FREE;
                    ctl.res_set    = 1'b1;
                    ctl.res_status = STATUS_RELEASED;
                    state_next     = S_DONE;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    state_next    = S_SCAN_READ;
                end
            end

            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lmdd_dp.sv
`default_nettype none

module lmdd_dp #(
    parameter int THREADS = 16,
    parameter int MUTEXES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lmdd_pkg::dp_ctl_t ctl,
    output lmdd_pkg::dp_stat_t     stat,
    input  wire lmdd_pkg::op_t     in_command,
    input  wire lmdd_pkg::tid_t    in_thread_id,
    input  wire lmdd_pkg::mid_t    in_mutex_id,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lmdd_pkg::status_t      out_status,
    output logic                   out_woken_valid,
    output lmdd_pkg::tid_t         out_woken_thread
);
    import lmdd_pkg::*;

    localparam int TW     = $clog2(THREADS);
    localparam int MW     = $clog2(MUTEXES);
    localparam int SW     = $clog2(THREADS + 1);
    localparam int MAXD   = (THREADS > MUTEXES) ? THREADS : MUTEXES;
    localparam int CW     = $clog2(MAXD);
    localparam int OWN_W  = TW + 1;
    localparam int WAIT_W = MW + 1;

    // Request registers.
    op_t           op_reg;
    logic [TW-1:0] tid_reg;
    logic [MW-1:0] mid_reg;
    logic          ok_reg;

    // Chain walk, scan and clearing counters.
    logic [TW-1:0] cur_reg;
    logic [TW-1:0] cur_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [TW-1:0] scan_reg;
    logic [TW-1:0] scan_next;
    logic [CW-1:0] clr_reg;
    logic [CW-1:0] clr_next;

    // Pending result and output register.
    status_t res_status_reg;
    logic    res_wv_reg;
    tid_t    res_wt_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t out_status_reg;
    logic    out_wv_reg;
    tid_t    out_wt_reg;

    // Table ports.
    logic              own_we;
    logic [MW-1:0]     own_waddr;
    logic [OWN_W-1:0]  own_wdata;
    logic [MW-1:0]     own_raddr;
    logic [OWN_W-1:0]  own_rdata;
    logic              wait_we;
    logic [TW-1:0]     wait_waddr;
    logic [WAIT_W-1:0] wait_wdata;
    logic [TW-1:0]     wait_raddr;
    logic [WAIT_W-1:0] wait_rdata;

    logic          own_rd_valid;
    logic [TW-1:0] own_rd_thread;
    logic          wait_rd_valid;
    logic [MW-1:0] wait_rd_mutex;

    logic [31:0] in_tid_wide;
    logic [31:0] in_mid_wide;
    logic [31:0] scan_wide;
    logic [31:0] clr_wide;
    logic        in_op_known;

    assign in_tid_wide = 32'(in_thread_id);
    assign in_mid_wide = 32'(in_mutex_id);
    assign scan_wide   = 32'(scan_reg);
    assign clr_wide    = 32'(clr_reg);
    assign in_op_known = (in_command == OP_LOCK) || (in_command == OP_TRY_LOCK)
                         || (in_command == OP_UNLOCK);

    // Capture the request; out-of-range fields and unknown commands are flagged here.
    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            op_reg  <= in_command;
            tid_reg <= in_tid_wide[TW-1:0];
            mid_reg <= in_mid_wide[MW-1:0];
            ok_reg  <= in_op_known && (in_tid_wide < 32'(THREADS))
                       && (in_mid_wide < 32'(MUTEXES));
        end
    end

    // Owner table: a valid bit and the owning thread for each mutex.
    lmdd_ram #(
        .WIDTH (OWN_W),
        .DEPTH (MUTEXES)
    ) u_own_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    // Wait table: a valid bit and the awaited mutex for each thread.
    lmdd_ram #(
        .WIDTH (WAIT_W),
        .DEPTH (THREADS)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (wait_wdata),
        .raddr (wait_raddr),
        .rdata (wait_rdata)
    );

    assign own_rd_valid  = own_rdata[TW];
    assign own_rd_thread = own_rdata[TW-1:0];
    assign wait_rd_valid = wait_rdata[MW];
    assign wait_rd_mutex = wait_rdata[MW-1:0];

    // Read addresses: the chain follows the waited-for mutex, the scan walks all threads.
    assign own_raddr  = ctl.own_rd_chain ? wait_rd_mutex : mid_reg;
    assign wait_raddr = ctl.wait_rd_scan ? scan_reg : cur_reg;

    // Owner table writes.
    always_comb
    begin
        own_we    = 1'b0;
        own_waddr = mid_reg;
        own_wdata = '0;
        case (ctl.own_wr)
            OWN_WR_NONE:
            begin
                own_we = 1'b0;
            end
            OWN_WR_CLEAR:
            begin
                own_we    = clr_wide < 32'(MUTEXES);
                own_waddr = clr_reg[MW-1:0];
            end
            OWN_WR_GRANT:
            begin
                own_we    = 1'b1;
                own_wdata = {1'b1, tid_reg};
            end
            OWN_WR_HAND:
            begin
                own_we    = 1'b1;
                own_wdata = {1'b1, scan_reg};
            end
            OWN_WR_FREE:
            begin
                own_we = 1'b1;
            end
            default:
            begin
                own_we = 1'b0;
            end
        endcase
    end

    // Wait table writes.
    always_comb
    begin
        wait_we    = 1'b0;
        wait_waddr = tid_reg;
        wait_wdata = '0;
        case (ctl.wait_wr)
            WAIT_WR_NONE:
            begin
                wait_we = 1'b0;
            end
            WAIT_WR_CLEAR:
            begin
                wait_we    = clr_wide < 32'(THREADS);
                wait_waddr = clr_reg[TW-1:0];
            end
            WAIT_WR_SET:
            begin
                wait_we    = 1'b1;
                wait_wdata = {1'b1, mid_reg};
            end
            WAIT_WR_DROP:
            begin
                wait_we = 1'b1;
            end
            WAIT_WR_WAKE:
            begin
                wait_we    = 1'b1;
                wait_waddr = scan_reg;
            end
            default:
            begin
                wait_we = 1'b0;
            end
        endcase
    end

    // Counter next values.
    always_comb
    begin
        clr_next  = ctl.clear_step ? clr_reg + CW'(1) : clr_reg;
        cur_next  = (ctl.chain_start || ctl.chain_step) ? own_rd_thread : cur_reg;
        step_next = step_reg;
        if (ctl.chain_start)
        begin
            step_next = '0;
        end
        else if (ctl.chain_step)
        begin
            step_next = step_reg + SW'(1);
        end
        scan_next = scan_reg;
        if (ctl.scan_start)
        begin
            scan_next = '0;
        end
        else if (ctl.scan_step)
        begin
            scan_next = scan_reg + TW'(1);
        end
    end

    // Output register is freed by a transfer and refilled by the controller.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            cur_reg       <= '0;
            step_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            step_reg      <= step_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; the woken thread reads zero when nobody was handed the mutex.
    always_ff @(posedge clk)
    begin
        if (ctl.res_set)
        begin
            res_status_reg <= ctl.res_status;
            res_wv_reg     <= ctl.res_woken;
            res_wt_reg     <= ctl.res_woken ? scan_wide[TID_W-1:0] : '0;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_wv_reg     <= res_wv_reg;
            out_wt_reg     <= res_wt_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.req_ok     = ok_reg;
        stat.op         = op_reg;
        stat.own_valid  = own_rd_valid;
        stat.own_is_req = own_rd_thread == tid_reg;
        stat.cur_is_req = cur_reg == tid_reg;
        stat.step_done  = step_reg == SW'(THREADS);
        stat.wait_valid = wait_rd_valid;
        stat.wait_match = wait_rd_mutex == mid_reg;
        stat.scan_last  = scan_reg == TW'(THREADS - 1);
        stat.clear_last = clr_wide == 32'(MAXD - 1);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_woken_valid  = out_wv_reg;
    assign out_woken_thread = out_wt_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lock_manager_deadlock_detect.sv
`default_nettype none

// Lock manager with deadlock detection. Each request transfer carries a lock, try-lock or
// unlock command for one thread and one mutex and yields exactly one result transfer. A lock
// on a free or self-owned mutex is granted; a lock on another thread's mutex walks the owner
// chain and either reports a deadlock or leaves the thread waiting; unlock hands the mutex to
// the lowest-numbered waiter. Requests are handled one at a time, and the next request is
// taken while the previous result waits in the output register. After reset the block sweeps
// both tables with req.ready low. Every chain step reads the wait table and then the owner
// table through their single read ports, and an unlock scans the wait table one thread at a
// time, starting from thread 0.
module lock_manager_deadlock_detect #(
    parameter int THREADS = 16,
    parameter int MUTEXES = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    lmdd_req_if.sink   req,
    lmdd_rsp_if.source rsp
);
    import lmdd_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;
    logic     in_ready;

    lmdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .ctl      (ctl),
        .stat     (stat)
    );

    lmdd_dp #(
        .THREADS (THREADS),
        .MUTEXES (MUTEXES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .in_command       (req.command),
        .in_thread_id     (req.thread_id),
        .in_mutex_id      (req.mutex_id),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_status       (rsp.status),
        .out_woken_valid  (rsp.woken_valid),
        .out_woken_thread (rsp.woken_thread)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire

// File: hw/rtl/lmdd_chk.sv
`default_nettype none

module lmdd_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire lmdd_pkg::status_t rsp_status,
    input wire logic              rsp_woken_valid,
    input wire lmdd_pkg::tid_t    rsp_woken_thread
);
    import lmdd_pkg::*;

    logic       req_xfer;
    logic       rsp_xfer;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // Requests taken whose result has not been delivered yet.
    always_comb
    begin
        pend_next = pend_reg + 2'(req_xfer) - 2'(rsp_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A result waiting for the sink holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_woken_valid) && $stable(rsp_woken_thread))
        else $error("result changed while stalled");

    // Every result answers an earlier request, and at most two are ever in flight.
    a_rsp_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd3) && (!rsp_xfer || pend_reg != 2'd0))
        else $error("results and requests out of balance");

    // Only a release hands a mutex over, and the woken thread is zero otherwise.
    a_woken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_woken_valid ? (rsp_status == STATUS_RELEASED)
                                       : (rsp_woken_thread == '0)))
        else $error("woken fields inconsistent with status");

    // One request at a time: the request side closes right after a transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> !req_ready)
        else $error("request taken while another is in progress");

endmodule

bind lock_manager_deadlock_detect lmdd_chk u_lmdd_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_woken_valid  (rsp.woken_valid),
    .rsp_woken_thread (rsp.woken_thread)
);

`default_nettype wire
